>>> sv/ycbcr_nearest_palette_index_defines.svh
// assertion macros for the nearest palette index block
// used by the checker module; no other dependencies
`ifndef YCBCR_NEAREST_PALETTE_INDEX_DEFINES_SVH
`define YCBCR_NEAREST_PALETTE_INDEX_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NPI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define NPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/npi_pkg.sv
// shared types and constants for the nearest palette index block
// no dependencies
`default_nettype none
package npi_pkg;
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int GAIN_W   = 18;
  localparam int PIX_W    = 8;
  localparam int ENTRY_W  = 24;
  localparam int CHROMA_W = 9;
  localparam int TGT_W    = 28;
  localparam int DIFF_W   = 29;
  localparam int ABS_W    = 28;
  localparam int SQ_W     = 56;
  localparam int SUM_W    = 58;
  localparam int DIST_W   = 52;
  localparam int CFG_IDX_W = 2;
  localparam logic [PIX_W-1:0] CHROMA_OFFSET = 8'd128;

  localparam logic [GAIN_W-1:0] RED_CR_RST   = 18'd91881;
  localparam logic [GAIN_W-1:0] GREEN_CB_RST = 18'd22554;
  localparam logic [GAIN_W-1:0] GREEN_CR_RST = 18'd46802;
  localparam logic [GAIN_W-1:0] BLUE_CB_RST  = 18'd116130;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RED_CR   = 2'd0,
    CFG_GREEN_CB = 2'd1,
    CFG_GREEN_CR = 2'd2,
    CFG_BLUE_CB  = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_TGT   = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

  // tag of one palette entry handed to the distance pipeline
  typedef struct packed {
    logic              valid;
    logic [PIX_W-1:0]  idx;
  } scan_tag_t;

  typedef enum logic {
    MODE_QUERY = 1'b0,
    MODE_LOAD  = 1'b1
  } mode_t;
endpackage
`default_nettype wire

>>> sv/npi_in_if.sv
// request channel carrying a query pixel or a palette load
// depends on npi_pkg
`default_nettype none
interface npi_in_if import npi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [PIX_W-1:0] luma;
  logic [PIX_W-1:0] chroma_blue;
  logic [PIX_W-1:0] chroma_red;
  logic [PIX_W-1:0] entry_slot;
  logic [PIX_W-1:0] entry_red;
  logic [PIX_W-1:0] entry_green;
  logic [PIX_W-1:0] entry_blue;
  modport source (output valid, mode, luma, chroma_blue, chroma_red, entry_slot,
                  entry_red, entry_green, entry_blue, input ready);
  modport sink (input valid, mode, luma, chroma_blue, chroma_red, entry_slot,
                entry_red, entry_green, entry_blue, output ready);
endinterface

// result channel carrying the nearest entry and its distance
interface npi_out_if import npi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  nearest_index;
  logic [DIST_W-1:0] best_distance;
  modport source (output valid, nearest_index, best_distance, input ready);
  modport sink (input valid, nearest_index, best_distance, output ready);
endinterface
`default_nettype wire

>>> sv/npi_cell.sv
// one palette cell of the rotating ring
// depends on npi_pkg
`default_nettype none
module npi_cell import npi_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load_en,
  input  wire logic [ENTRY_W-1:0] load_data,
  input  wire logic               shift_en,
  input  wire logic [ENTRY_W-1:0] shift_in,
  output logic      [ENTRY_W-1:0] q
);
  logic [ENTRY_W-1:0] entry_r;

  // load wins; queries and loads never overlap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else if (load_en) begin
      entry_r <= load_data;
    end else if (shift_en) begin
      entry_r <= shift_in;
    end
  end

  assign q = entry_r;
endmodule
`default_nettype wire

>>> sv/npi_dist.sv
// distance pipeline and running minimum for one query
// depends on npi_pkg
`default_nettype none
module npi_dist import npi_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic signed [TGT_W-1:0] tgt_r_i,
  input  wire logic signed [TGT_W-1:0] tgt_g_i,
  input  wire logic signed [TGT_W-1:0] tgt_b_i,
  input  wire logic [ENTRY_W-1:0]      entry_i,
  input  wire scan_tag_t               tag_i,
  output logic                         busy,
  output logic [PIX_W-1:0]             best_idx,
  output logic [SUM_W-1:0]             best_dist
);
  scan_tag_t         tag1_r, tag2_r, tag3_r;
  logic [ABS_W-1:0]  ar_r, ag_r, ab_r;
  logic [SQ_W-1:0]   sr_r, sg_r, sb_r;
  logic [SUM_W-1:0]  sum_r;
  logic [PIX_W-1:0]  best_idx_r;
  logic [SUM_W-1:0]  best_r;
  logic signed [DIFF_W-1:0] dr, dg, db;

  // entry value in q16 minus target
  assign dr = $signed({5'b0, entry_i[23:16], 16'b0}) - DIFF_W'(tgt_r_i);
  assign dg = $signed({5'b0, entry_i[15:8], 16'b0}) - DIFF_W'(tgt_g_i);
  assign db = $signed({5'b0, entry_i[7:0], 16'b0}) - DIFF_W'(tgt_b_i);

  // stage tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  // absolute differences, squares, sum
  always_ff @(posedge clk) begin
    ar_r  <= ABS_W'(dr[DIFF_W-1] ? -dr : dr);
    ag_r  <= ABS_W'(dg[DIFF_W-1] ? -dg : dg);
    ab_r  <= ABS_W'(db[DIFF_W-1] ? -db : db);
    sr_r  <= ar_r * ar_r;
    sg_r  <= ag_r * ag_r;
    sb_r  <= ab_r * ab_r;
    sum_r <= SUM_W'(sr_r) + SUM_W'(sg_r) + SUM_W'(sb_r);
  end

  // keep first strict minimum, entry zero always seeds
  always_ff @(posedge clk) begin
    if (tag3_r.valid && (tag3_r.idx == '0 || sum_r < best_r)) begin
      best_r     <= sum_r;
      best_idx_r <= tag3_r.idx;
    end
  end

  assign busy      = tag1_r.valid | tag2_r.valid | tag3_r.valid;
  assign best_idx  = best_idx_r;
  assign best_dist = best_r;
endmodule
`default_nettype wire

>>> sv/ycbcr_nearest_palette_index.sv
// Nearest palette index search for a YCbCr pixel.
// Requests arrive on in_ch (valid/ready). A load request (mode 1) writes one
// palette entry in the accept cycle and produces no result; slots at or beyond
// PALETTE_ENTRIES are dropped. A query request (mode 0) converts the pixel to
// RGB in q16 and produces one result on out_ch: the lowest index with the
// smallest squared distance and that distance in q32 (low 52 bits).
// The palette sits in a ring of cells that rotates one step per cycle past a
// four-stage distance pipeline. One query is worked at a time: in_ch.ready is
// high only while idle. The result sits in an output register; while the
// receiver stalls, the block accepts further requests, and a following query
// holds its result back until the register is free. Reset (rst_n low,
// synchronous) clears the palette to black, loads the default gains and
// empties the result register. Gains are to be written through cfg_* only
// while idle; the block itself does not enforce this.
`default_nettype none
module ycbcr_nearest_palette_index import npi_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [GAIN_W-1:0]    cfg_wdata,
  npi_in_if.sink                    in_ch,
  npi_out_if.source                 out_ch
);
  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

  state_t state_r, state_nxt;
  logic [GAIN_W-1:0] g_rcr_r, g_gcb_r, g_gcr_r, g_bcb_r;
  logic [PIX_W-1:0]  luma_r;
  logic signed [CHROMA_W-1:0] cb_r, cr_r;
  logic signed [TGT_W-1:0] p_rcr_r, p_gcb_r, p_gcr_r, p_bcb_r;
  logic signed [TGT_W-1:0] tgt_r_r, tgt_g_r, tgt_b_r, y_q;
  logic [IDX_W-1:0] scan_cnt_r;
  logic [ENTRY_W-1:0] cell_q [PALETTE_ENTRIES];
  logic accept, load_acc, query_acc, slot_ok, out_free, finish;
  scan_tag_t tag;
  logic dist_busy;
  logic [PIX_W-1:0] best_idx;
  logic [SUM_W-1:0] best_dist;
  logic out_valid_r;
  logic [PIX_W-1:0]  out_idx_r;
  logic [DIST_W-1:0] out_dist_r;

  assign accept    = in_ch.valid && in_ch.ready;
  assign load_acc  = accept && (in_ch.mode == MODE_LOAD);
  assign query_acc = accept && (in_ch.mode == MODE_QUERY);
  assign slot_ok   = {1'b0, in_ch.entry_slot} < 9'(PALETTE_ENTRIES);
  assign in_ch.ready = (state_r == ST_IDLE);

  // gain registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_rcr_r <= RED_CR_RST;
      g_gcb_r <= GREEN_CB_RST;
      g_gcr_r <= GREEN_CR_RST;
      g_bcb_r <= BLUE_CB_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RED_CR:   g_rcr_r <= cfg_wdata;
        CFG_GREEN_CB: g_gcb_r <= cfg_wdata;
        CFG_GREEN_CR: g_gcr_r <= cfg_wdata;
        CFG_BLUE_CB:  g_bcb_r <= cfg_wdata;
      endcase
    end
  end

  // palette ring, head cell feeds the distance pipeline
  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    npi_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load_en   (load_acc && slot_ok && (in_ch.entry_slot == PIX_W'(i))),
      .load_data ({in_ch.entry_red, in_ch.entry_green, in_ch.entry_blue}),
      .shift_en  (state_r == ST_SCAN),
      .shift_in  (cell_q[(i + 1) % PALETTE_ENTRIES]),
      .q         (cell_q[i])
    );
  end

  // pixel capture, chroma offsets removed
  always_ff @(posedge clk) begin
    if (query_acc) begin
      luma_r <= in_ch.luma;
      cb_r   <= $signed({1'b0, in_ch.chroma_blue}) - $signed({1'b0, CHROMA_OFFSET});
      cr_r   <= $signed({1'b0, in_ch.chroma_red}) - $signed({1'b0, CHROMA_OFFSET});
    end
  end

  // gain products, then rgb targets in q16
  assign y_q = $signed({4'b0, luma_r, 16'b0});
  always_ff @(posedge clk) begin
    p_rcr_r <= $signed({1'b0, g_rcr_r}) * cr_r;
    p_gcb_r <= $signed({1'b0, g_gcb_r}) * cb_r;
    p_gcr_r <= $signed({1'b0, g_gcr_r}) * cr_r;
    p_bcb_r <= $signed({1'b0, g_bcb_r}) * cb_r;
    if (state_r == ST_TGT) begin
      tgt_r_r <= y_q + p_rcr_r;
      tgt_g_r <= y_q - p_gcb_r - p_gcr_r;
      tgt_b_r <= y_q + p_bcb_r;
    end
  end

  // scan counter, one full turn of the ring per query
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
    end else if (state_r == ST_SCAN) begin
      scan_cnt_r <= (scan_cnt_r == LAST_IDX) ? '0 : scan_cnt_r + 1'b1;
    end
  end

  assign tag.valid = (state_r == ST_SCAN);
  assign tag.idx   = PIX_W'(scan_cnt_r);

  npi_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .tgt_r_i   (tgt_r_r),
    .tgt_g_i   (tgt_g_r),
    .tgt_b_i   (tgt_b_r),
    .entry_i   (cell_q[0]),
    .tag_i     (tag),
    .busy      (dist_busy),
    .best_idx  (best_idx),
    .best_dist (best_dist)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign finish   = (state_r == ST_DRAIN) && !dist_busy && out_free;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (query_acc) state_nxt = ST_CONV;
      ST_CONV:  state_nxt = ST_TGT;
      ST_TGT:   state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_cnt_r == LAST_IDX) state_nxt = ST_DRAIN;
      ST_DRAIN: if (finish) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_idx_r  <= best_idx;
      out_dist_r <= best_dist[DIST_W-1:0];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.nearest_index = out_idx_r;
  assign out_ch.best_distance = out_dist_r;
endmodule
`default_nettype wire

>>> sv/npi_chk.sv
// port-level checker for the nearest palette index block, bound to the top
// depends on ycbcr_nearest_palette_index_defines.svh
`include "ycbcr_nearest_palette_index_defines.svh"
`default_nettype none
module npi_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_mode,
  input wire logic out_valid,
  input wire logic out_ready
);
  // result held until taken
  `NPI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  // a query blocks further requests
  `NPI_ASSERT_NEXT(a_query_busy, clk, rst_n, in_valid && in_ready && !in_mode, !in_ready, "query not busy")
  // a load keeps the block idle
  `NPI_ASSERT_NEXT(a_load_idle, clk, rst_n, in_valid && in_ready && in_mode, in_ready, "load stalled")
  // a new result only comes out of a running query
  `NPI_ASSERT_NOW(a_out_src, clk, rst_n, $rose(out_valid), !$past(in_ready), "spurious result")
endmodule
`default_nettype wire

bind ycbcr_nearest_palette_index npi_chk u_npi_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

>>> test/ycbcr_nearest_palette_index_test.sv
// self-checking testbench for the ycbcr nearest palette index block
// depends on npi_pkg, npi_in_if, npi_out_if and ycbcr_nearest_palette_index
`default_nettype none
module ycbcr_nearest_palette_index_test;
  import npi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = PALETTE_ENTRIES_DEF;
  localparam int DRAIN_CYCLES = ENTRIES + 40;
  localparam int ITEMS_PER_SEGMENT = 122;
  localparam int SEGMENTS = 6;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    mode_t            mode;
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
    logic [PIX_W-1:0] slot;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pal_req_t;

  typedef struct {
    logic [PIX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
  } nearest_t;

  typedef struct {
    pal_req_t req;
    bit       typed;
    nearest_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_RED_CR;
  logic [GAIN_W-1:0] cfg_wdata = '0;

  npi_in_if in_ch ();
  npi_out_if out_ch ();

  ycbcr_nearest_palette_index dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the block state
  logic [GAIN_W-1:0] gain_red_cr, gain_green_cb, gain_green_cr, gain_blue_cb;
  logic [PIX_W-1:0] pal_red [ENTRIES];
  logic [PIX_W-1:0] pal_green [ENTRIES];
  logic [PIX_W-1:0] pal_blue [ENTRIES];

  nearest_t pending_results[$];
  int mismatches = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;

  function automatic longint unsigned squared_error(logic [PIX_W-1:0] entry, longint target);
    longint d;
    d = longint'(entry) * 65536 - target;
    if (d < 0) d = -d;
    return longint'(d) * longint'(d);
  endfunction

  // convert the pixel and search the palette, first strict minimum wins
  function automatic nearest_t find_nearest(pal_req_t r);
    longint y_q, cb_off, cr_off, tr, tg, tb;
    longint unsigned cand_dist, best;
    nearest_t res;
    y_q = longint'(r.luma) * 65536;
    cb_off = longint'(r.cb) - longint'(CHROMA_OFFSET);
    cr_off = longint'(r.cr) - longint'(CHROMA_OFFSET);
    tr = y_q + longint'(gain_red_cr) * cr_off;
    tg = y_q - longint'(gain_green_cb) * cb_off - longint'(gain_green_cr) * cr_off;
    tb = y_q + longint'(gain_blue_cb) * cb_off;
    best = 0;
    res.index = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      cand_dist = squared_error(pal_red[i], tr) + squared_error(pal_green[i], tg)
                + squared_error(pal_blue[i], tb);
      if (i == 0 || cand_dist < best) begin
        best = cand_dist;
        res.index = PIX_W'(i);
      end
    end
    res.distance = best[DIST_W-1:0];
    return res;
  endfunction

  // update shadow state for an accepted request
  task automatic note_accepted(pal_req_t r, bit typed, nearest_t want);
    if (r.mode == MODE_LOAD) begin
      if (int'(r.slot) < ENTRIES) begin
        pal_red[r.slot] = r.red;
        pal_green[r.slot] = r.green;
        pal_blue[r.slot] = r.blue;
      end
    end else begin
      pending_results.push_back(typed ? want : find_nearest(r));
    end
  endtask

  task automatic issue_request(pal_req_t r, bit typed, nearest_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.mode = r.mode;
    in_ch.luma = r.luma;
    in_ch.chroma_blue = r.cb;
    in_ch.chroma_red = r.cr;
    in_ch.entry_slot = r.slot;
    in_ch.entry_red = r.red;
    in_ch.entry_green = r.green;
    in_ch.entry_blue = r.blue;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    note_accepted(r, typed, want);
    @(negedge clk);
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_gain(cfg_idx_t idx, logic [GAIN_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    case (idx)
      CFG_RED_CR:   gain_red_cr = value;
      CFG_GREEN_CB: gain_green_cb = value;
      CFG_GREEN_CR: gain_green_cr = value;
      CFG_BLUE_CB:  gain_blue_cb = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] chroma_pick();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  function automatic pal_req_t random_request();
    pal_req_t r;
    r.luma = PIX_W'($urandom_range(255));
    r.cb = chroma_pick();
    r.cr = chroma_pick();
    r.slot = ($urandom_range(3) == 0) ? PIX_W'($urandom_range(15)) : PIX_W'($urandom_range(255));
    r.red = PIX_W'($urandom_range(255));
    r.green = PIX_W'($urandom_range(255));
    r.blue = PIX_W'($urandom_range(255));
    r.mode = ($urandom_range(99) < 35) ? MODE_LOAD : MODE_QUERY;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    nearest_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result index %0d distance %0d",
                   out_ch.nearest_index, out_ch.best_distance);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.nearest_index !== want.index || out_ch.best_distance !== want.distance) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected index %0d distance %0d, got %0d %0d",
                     want.index, want.distance, out_ch.nearest_index, out_ch.best_distance);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= receiver_idle_pct);
  end

  // run limit
  initial begin
    #20_000_000;
    $display("ycbcr_nearest_palette_index verification failed");
    $finish;
  end

  initial begin
    nearest_t none;
    logic [GAIN_W-1:0] seg_gain [4];
    dir_row_t dir_rows [20];
    none = '{index: '0, distance: '0};
    dir_rows = '{
      // empty palette: always entry 0
      '{'{MODE_QUERY, 8'd0, 8'd128, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 52'd0}},
      '{'{MODE_QUERY, 8'd255, 8'd128, 8'd128, 8'd9, 8'd255, 8'd255, 8'd255}, 1'b1,
        '{8'd0, 52'd195075 << 32}},
      '{'{MODE_QUERY, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '{8'd0, 52'd0}},
      '{'{MODE_QUERY, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '{8'd0, 52'd0}},
      // white in the top slot, query fields ignored
      '{'{MODE_LOAD, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b0,
        '{8'd0, 52'd0}},
      '{'{MODE_QUERY, 8'd255, 8'd128, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd255, 52'd0}},
      // tie between slot 0 and slot 255 goes low
      '{'{MODE_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255}, 1'b0, '{8'd0, 52'd0}},
      '{'{MODE_QUERY, 8'd255, 8'd128, 8'd128, 8'd255, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 52'd0}},
      '{'{MODE_LOAD, 8'd77, 8'd3, 8'd200, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '{8'd0, 52'd0}},
      '{'{MODE_LOAD, 8'd0, 8'd0, 8'd0, 8'd17, 8'd255, 8'd0, 8'd0}, 1'b0, '{8'd0, 52'd0}},
      '{'{MODE_LOAD, 8'd0, 8'd0, 8'd0, 8'd200, 8'd0, 8'd255, 8'd0}, 1'b0, '{8'd0, 52'd0}},
      '{'{MODE_LOAD, 8'd0, 8'd0, 8'd0, 8'd201, 8'd0, 8'd0, 8'd255}, 1'b0, '{8'd0, 52'd0}},
      '{'{MODE_QUERY, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '{8'd0, 52'd0}},
      '{'{MODE_QUERY, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '{8'd0, 52'd0}},
      '{'{MODE_QUERY, 8'd128, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '{8'd0, 52'd0}},
      '{'{MODE_QUERY, 8'd76, 8'd85, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '{8'd0, 52'd0}},
      '{'{MODE_LOAD, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128, 8'd128}, 1'b0, '{8'd0, 52'd0}},
      '{'{MODE_QUERY, 8'd128, 8'd128, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd128, 52'd0}},
      '{'{MODE_QUERY, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '{8'd0, 52'd0}},
      '{'{MODE_QUERY, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '{8'd0, 52'd0}}
    };

    // known values on every input before reset
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_QUERY;
    in_ch.luma = '0;
    in_ch.chroma_blue = '0;
    in_ch.chroma_red = '0;
    in_ch.entry_slot = '0;
    in_ch.entry_red = '0;
    in_ch.entry_green = '0;
    in_ch.entry_blue = '0;
    out_ch.ready = 1'b0;
    gain_red_cr = RED_CR_RST;
    gain_green_cb = GREEN_CB_RST;
    gain_green_cr = GREEN_CR_RST;
    gain_blue_cb = BLUE_CB_RST;
    for (int i = 0; i < ENTRIES; i++) begin
      pal_red[i] = '0;
      pal_green[i] = '0;
      pal_blue[i] = '0;
    end

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table
    sender_idle_pct = 9;
    receiver_idle_pct = 79;
    foreach (dir_rows[i]) issue_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    // random segments, each under its own gain setting
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      case (seg)
        0: seg_gain = '{RED_CR_RST, GREEN_CB_RST, GREEN_CR_RST, BLUE_CB_RST};
        1: seg_gain = '{18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF};
        2: seg_gain = '{18'd0, 18'd0, 18'd0, 18'd0};
        5: seg_gain = '{18'h3FFFF, 18'd0, 18'h3FFFF, 18'd0};
        default: foreach (seg_gain[k]) seg_gain[k] = GAIN_W'($urandom_range(18'h3FFFF));
      endcase
      write_gain(CFG_RED_CR, seg_gain[0]);
      write_gain(CFG_GREEN_CB, seg_gain[1]);
      write_gain(CFG_GREEN_CR, seg_gain[2]);
      write_gain(CFG_BLUE_CB, seg_gain[3]);
      sender_idle_pct = (seg < 2) ? 9 : (seg < 4) ? 79 : 0;
      receiver_idle_pct = (seg < 2) ? 79 : (seg < 4) ? 9 : 0;
      for (int n = 0; n < ITEMS_PER_SEGMENT; n++) issue_request(random_request(), 1'b0, none);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("ycbcr_nearest_palette_index verification clean");
    end else begin
      $display("ycbcr_nearest_palette_index verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
